// ===== src/ipr_pkg.sv =====
// ----------------------------------------------------------------------------
// ipr_pkg
// shared types and constants of the instruction relocation patcher
// ----------------------------------------------------------------------------
package ipr_pkg;

  // patch kinds
  typedef enum logic [2:0] {
    CMD_MASKED      = 3'd0,
    CMD_MASKED_DIST = 3'd1,
    CMD_PAGE        = 3'd2,
    CMD_IMM16       = 3'd3,
    CMD_POINTER     = 3'd4
  } cmd_e;

  // configuration register indexes
  localparam logic REG_DIST = 1'b0;
  localparam logic REG_BASE = 1'b1;

  // one quotient bit per divider step
  localparam int unsigned DIV_STEPS = 32;

  // adrp and movw/movt field layout
  localparam logic [31:0] PAGE_HI_MASK  = 32'h0007_FFFF;
  localparam logic [31:0] PAGE_LO_MASK  = 32'h0000_0003;
  localparam int unsigned PAGE_HI_SHIFT = 5;
  localparam int unsigned PAGE_LO_SHIFT = 29;
  localparam logic [31:0] IMM_LO_MASK   = 32'h0000_0FFF;
  localparam logic [31:0] IMM_HI_MASK   = 32'h0000_000F;
  localparam int unsigned IMM_HI_SHIFT  = 16;

  // classified request handed from front to back
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] word;
    logic [31:0] mask;
    logic [31:0] a;        // first dividend magnitude, becomes quotient
    logic [31:0] b;        // second dividend magnitude, becomes quotient
    logic [31:0] d;        // divisor magnitude
    logic        a_neg;
    logic        a_floor;
    logic        b_neg;
    logic        err;
  } op_t;

  // divider stage contents
  typedef struct packed {
    op_t         op;
    logic [31:0] rem_a;
    logic [31:0] rem_b;
  } stage_t;

  // combined quotient before field insertion
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] word;
    logic [31:0] mask;
    logic [31:0] q;
    logic        err;
  } fix_t;

  // one restoring division step: returns {remainder, shifted dividend/quotient}
  function automatic logic [63:0] div_step(input logic [31:0] rem,
                                           input logic [31:0] dvd,
                                           input logic [31:0] d);
    logic [32:0] t;
    logic [32:0] s;
    t = {rem, dvd[31]};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      div_step = {s[31:0], dvd[30:0], 1'b1};
    end else begin
      div_step = {t[31:0], dvd[30:0], 1'b0};
    end
  endfunction

endpackage

// ===== src/ipr_front.sv =====
// ----------------------------------------------------------------------------
// ipr_front
// configuration registers and request classification into divider operands
// ----------------------------------------------------------------------------
module ipr_front #(
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [ADDRESS_BITS-1:0] cfg_data_i,
  input  logic [2:0]              cmd_i,
  input  logic [31:0]             original_word_i,
  input  logic [30:0]             code_offset_i,
  input  logic [31:0]             field_mask_i,
  input  logic signed [31:0]      scale_i,
  input  logic signed [31:0]      value_i,
  output ipr_pkg::op_t            op_o,
  output logic [ADDRESS_BITS-1:0] ptr_o
);

  logic [31:0]             dist_q;
  logic [ADDRESS_BITS-1:0] base_q;
  logic [31:0]             sum;
  logic [31:0]             addr_lo;
  logic                    s_neg;
  logic [31:0]             s_mag;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= '0;
      base_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ipr_pkg::REG_DIST: dist_q <= cfg_data_i[31:0];
        ipr_pkg::REG_BASE: base_q <= cfg_data_i;
        default:           base_q <= base_q;
      endcase
    end
  end

  // data pointer and sums
  assign ptr_o   = base_q + ADDRESS_BITS'(value_i);
  assign addr_lo = ptr_o[31:0] & field_mask_i;
  assign sum     = dist_q + value_i;
  assign s_neg   = scale_i[31];
  assign s_mag   = s_neg ? (32'd0 - scale_i) : scale_i;

  // classify and set up dividends
  always_comb begin
    op_o         = '0;
    op_o.cmd     = ipr_pkg::cmd_e'(cmd_i);
    op_o.word    = original_word_i;
    op_o.mask    = field_mask_i;
    op_o.d       = s_mag;
    op_o.err     = (cmd_i > 3'd4) || ((cmd_i < 3'd4) && (scale_i == 32'sd0));
    case (ipr_pkg::cmd_e'(cmd_i))
      ipr_pkg::CMD_MASKED, ipr_pkg::CMD_MASKED_DIST: begin
        op_o.a     = value_i[31] ? (32'd0 - value_i) : value_i;
        op_o.a_neg = value_i[31] ^ s_neg;
        if (cmd_i == 3'(ipr_pkg::CMD_MASKED_DIST)) begin
          op_o.b     = dist_q[31] ? (32'd0 - dist_q) : dist_q;
          op_o.b_neg = dist_q[31] ^ s_neg;
        end
      end
      ipr_pkg::CMD_PAGE: begin
        op_o.a       = sum[31] ? (32'd0 - sum) : sum;
        op_o.a_neg   = sum[31] ^ s_neg;
        op_o.a_floor = 1'b1;
        op_o.b       = {1'b0, code_offset_i};
        op_o.b_neg   = s_neg;
      end
      ipr_pkg::CMD_IMM16: begin
        op_o.a = addr_lo;
        op_o.d = scale_i;
      end
      default: begin
        op_o.a = '0;
      end
    endcase
  end

endmodule

// ===== src/ipr_queue.sv =====
// ----------------------------------------------------------------------------
// ipr_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module ipr_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q;
  logic             rd_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== src/ipr_back.sv =====
// ----------------------------------------------------------------------------
// ipr_back
// pipelined dual divider, quotient fix-up and field insertion
// ----------------------------------------------------------------------------
module ipr_back #(
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  ipr_pkg::op_t            op_i,
  input  logic [ADDRESS_BITS-1:0] ptr_i,
  output logic                    take_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [31:0]             patched_word_o,
  output logic [ADDRESS_BITS-1:0] pointer_value_o,
  output logic                    error_o
);

  localparam int unsigned NS = ipr_pkg::DIV_STEPS;

  ipr_pkg::stage_t         stg_q [NS];
  ipr_pkg::stage_t         stg_d [NS];
  logic [ADDRESS_BITS-1:0] sptr_q [NS];
  logic [NS-1:0]           sv_q;
  ipr_pkg::fix_t           fix_q, fix_d;
  logic [ADDRESS_BITS-1:0] fptr_q;
  logic                    fv_q;
  logic                    en;
  logic [31:0]             word_d;
  logic [31:0]             low_bit;
  logic [31:0]             ins;
  logic [31:0]             qa, qb;
  ipr_pkg::stage_t         src;
  ipr_pkg::op_t            fop;

  // whole pipe moves unless the result register is held
  assign en     = !(out_valid_o && out_stall_i);
  assign take_o = en && valid_i;

  // one quotient bit per stage for both dividers
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        src.op    = op_i;
        src.rem_a = '0;
        src.rem_b = '0;
      end else begin
        src = stg_q[k-1];
      end
      stg_d[k] = src;
      {stg_d[k].rem_a, stg_d[k].op.a} = ipr_pkg::div_step(src.rem_a, src.op.a, src.op.d);
      {stg_d[k].rem_b, stg_d[k].op.b} = ipr_pkg::div_step(src.rem_b, src.op.b, src.op.d);
    end
  end

  // sign and floor fix-up, then combine the two quotients for the distance and page kinds
  always_comb begin
    fop = stg_q[NS-1].op;
    if (fop.a_neg) begin
      qa = (fop.a_floor && (stg_q[NS-1].rem_a != 32'd0)) ? ~fop.a : (32'd0 - fop.a);
    end else begin
      qa = fop.a;
    end
    qb = fop.b_neg ? (32'd0 - fop.b) : fop.b;
    fix_d.cmd  = fop.cmd;
    fix_d.word = fop.word;
    fix_d.mask = fop.mask;
    fix_d.err  = fop.err;
    case (fop.cmd)
      ipr_pkg::CMD_MASKED_DIST: fix_d.q = qa + qb;
      ipr_pkg::CMD_PAGE:        fix_d.q = qa - qb;
      default:                  fix_d.q = qa;
    endcase
  end

  // field insertion
  always_comb begin
    low_bit = fix_q.mask & (32'd0 - fix_q.mask);
    ins     = 32'(fix_q.q * low_bit);
    case (fix_q.cmd)
      ipr_pkg::CMD_MASKED, ipr_pkg::CMD_MASKED_DIST: begin
        word_d = (fix_q.word & ~fix_q.mask) | (ins & fix_q.mask);
      end
      ipr_pkg::CMD_PAGE: begin
        word_d = fix_q.word & ~((ipr_pkg::PAGE_HI_MASK << ipr_pkg::PAGE_HI_SHIFT)
                              | (ipr_pkg::PAGE_LO_MASK << ipr_pkg::PAGE_LO_SHIFT));
        word_d = word_d | (((fix_q.q >> 2) & ipr_pkg::PAGE_HI_MASK) << ipr_pkg::PAGE_HI_SHIFT)
                        | ((fix_q.q & ipr_pkg::PAGE_LO_MASK) << ipr_pkg::PAGE_LO_SHIFT);
      end
      ipr_pkg::CMD_IMM16: begin
        word_d = fix_q.word & ~((ipr_pkg::IMM_HI_MASK << ipr_pkg::IMM_HI_SHIFT)
                              | ipr_pkg::IMM_LO_MASK);
        word_d = word_d | (((fix_q.q >> 12) & ipr_pkg::IMM_HI_MASK) << ipr_pkg::IMM_HI_SHIFT)
                        | (fix_q.q & ipr_pkg::IMM_LO_MASK);
      end
      ipr_pkg::CMD_POINTER: word_d = fptr_q[31:0];
      default:              word_d = fix_q.word;
    endcase
    if (fix_q.err) begin
      word_d = fix_q.word;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        stg_q[k] <= stg_d[k];
      end
      sptr_q[0] <= ptr_i;
      for (int k = 1; k < NS; k++) begin
        sptr_q[k] <= sptr_q[k-1];
      end
      fix_q          <= fix_d;
      fptr_q         <= sptr_q[NS-1];
      patched_word_o <= word_d;
      pointer_value_o <= (fix_q.cmd == ipr_pkg::CMD_POINTER && !fix_q.err) ? fptr_q : '0;
      error_o        <= fix_q.err;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q        <= '0;
      fv_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      sv_q        <= {sv_q[NS-2:0], valid_i};
      fv_q        <= sv_q[NS-1];
      out_valid_o <= fv_q;
    end
  end

endmodule

// ===== src/instruction_relocation_patcher.sv =====
// ----------------------------------------------------------------------------
// instruction_relocation_patcher
// patches relocation immediates and data pointers into instruction words
// ----------------------------------------------------------------------------
// an accepted request passes the queue, the 32 divider steps, the quotient
//   fix-up and the output register
// throughput: one request per cycle when not held, set by the fully pipelined divider
// reset: clears configuration registers, queue count and all valid bits
// ----------------------------------------------------------------------------
module instruction_relocation_patcher #(
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [ADDRESS_BITS-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [2:0]              cmd_i,
  input  logic [31:0]             original_word_i,
  input  logic [30:0]             code_offset_i,
  input  logic [31:0]             field_mask_i,
  input  logic signed [31:0]      scale_i,
  input  logic signed [31:0]      value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [31:0]             patched_word_o,
  output logic [ADDRESS_BITS-1:0] pointer_value_o,
  output logic                    error_o
);

  localparam int unsigned QW = $bits(ipr_pkg::op_t) + ADDRESS_BITS;

  ipr_pkg::op_t            f_op;
  logic [ADDRESS_BITS-1:0] f_ptr;
  logic                    q_full;
  logic                    q_valid;
  logic                    q_pop;
  logic [QW-1:0]           q_data;
  ipr_pkg::op_t            b_op;
  logic [ADDRESS_BITS-1:0] b_ptr;
  logic                    push;

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  // classification
  ipr_front #(.ADDRESS_BITS(ADDRESS_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i, .original_word_i, .code_offset_i, .field_mask_i, .scale_i, .value_i,
    .op_o  (f_op),
    .ptr_o (f_ptr)
  );

  // decoupling queue
  ipr_queue #(.WIDTH(QW)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  ({f_op, f_ptr}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  assign {b_op, b_ptr} = q_data;

  // divide and patch
  ipr_back #(.ADDRESS_BITS(ADDRESS_BITS)) u_back (
    .clk_i, .rst_ni,
    .valid_i (q_valid),
    .op_i    (b_op),
    .ptr_i   (b_ptr),
    .take_o  (q_pop),
    .out_valid_o, .out_stall_i, .patched_word_o, .pointer_value_o, .error_o
  );

  // checks
  a_no_pop_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !q_pop) else $error("queue popped while output held");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");

  a_err_no_pointer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (pointer_value_o == '0)) else $error("pointer on error");

endmodule

// ===== tb/ipr_checker.sv =====
// ----------------------------------------------------------------------------
// ipr_checker
// watches the request and result channels of the relocation patcher,
// predicts each patched word and compares it field by field
// ----------------------------------------------------------------------------
module ipr_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [47:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         cmd_i,
  input  logic [31:0]        original_word_i,
  input  logic [30:0]        code_offset_i,
  input  logic [31:0]        field_mask_i,
  input  logic signed [31:0] scale_i,
  input  logic signed [31:0] value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [31:0]        patched_word_i,
  input  logic [47:0]        pointer_value_i,
  input  logic               error_i,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [47:0] ptr;
    logic        err;
  } patch_t;

  patch_t      patch_q[$];
  logic [31:0] dist_q;
  logic [47:0] base_q;
  int unsigned mismatches;

  assign pending_o    = patch_q.size();
  assign fail_count_o = mismatches;

  // truncating quotient wrapped to 32 bits
  function automatic logic [31:0] trunc_quot(longint a, longint b);
    longint q;
    q = a / b;
    return q[31:0];
  endfunction

  // flooring quotient wrapped to 32 bits
  function automatic logic [31:0] floor_quot(longint a, longint b);
    longint q;
    longint r;
    q = a / b;
    r = a % b;
    if (r != 0 && ((a < 0) != (b < 0))) q = q - 1;
    return q[31:0];
  endfunction

  // expected result of one relocation request
  function automatic patch_t patch_predict(logic [2:0] cmd, logic [31:0] word,
                                           logic [30:0] offs, logic [31:0] mask,
                                           logic signed [31:0] scale,
                                           logic signed [31:0] value);
    patch_t      r;
    longint      sc;
    longint      va;
    longint      di;
    logic [31:0] q;
    logic [31:0] low;
    logic [31:0] sum;
    logic [31:0] a;
    logic [31:0] imm;
    logic [63:0] addr;
    sc   = longint'(scale);
    va   = longint'(value);
    di   = longint'(signed'(dist_q));
    addr = {16'b0, base_q} + 64'(va);
    low  = mask & (32'd0 - mask);
    r.word = word;
    r.ptr  = '0;
    r.err  = 1'b0;
    if (cmd > ipr_pkg::CMD_POINTER || (cmd != ipr_pkg::CMD_POINTER && scale == 0)) begin
      r.err = 1'b1;
    end else begin
      case (cmd)
        ipr_pkg::CMD_MASKED, ipr_pkg::CMD_MASKED_DIST: begin
          q = trunc_quot(va, sc);
          if (cmd == ipr_pkg::CMD_MASKED_DIST) q = q + trunc_quot(di, sc);
          r.word = (word & ~mask) | ((q * low) & mask);
        end
        ipr_pkg::CMD_PAGE: begin
          sum = 32'(di + va);
          q = floor_quot(longint'(signed'(sum)), sc) -
              trunc_quot(longint'({1'b0, offs}), sc);
          r.word = word & ~((ipr_pkg::PAGE_HI_MASK << ipr_pkg::PAGE_HI_SHIFT) |
                            (ipr_pkg::PAGE_LO_MASK << ipr_pkg::PAGE_LO_SHIFT));
          r.word |= ((q >> 2) & ipr_pkg::PAGE_HI_MASK) << ipr_pkg::PAGE_HI_SHIFT;
          r.word |= (q & ipr_pkg::PAGE_LO_MASK) << ipr_pkg::PAGE_LO_SHIFT;
        end
        ipr_pkg::CMD_IMM16: begin
          a   = addr[31:0] & mask;
          imm = a / unsigned'(scale);
          r.word = word & ~((ipr_pkg::IMM_HI_MASK << ipr_pkg::IMM_HI_SHIFT) |
                            ipr_pkg::IMM_LO_MASK);
          r.word |= ((imm >> 12) & ipr_pkg::IMM_HI_MASK) << ipr_pkg::IMM_HI_SHIFT;
          r.word |= imm & ipr_pkg::IMM_LO_MASK;
        end
        default: begin
          r.ptr  = addr[47:0];
          r.word = addr[31:0];
        end
      endcase
    end
    return r;
  endfunction

  // track config, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    patch_t exp_r;
    if (!rst_ni) begin
      dist_q     <= '0;
      base_q     <= '0;
      mismatches <= 0;
      patch_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == ipr_pkg::REG_DIST) dist_q <= cfg_data_i[31:0];
        else base_q <= cfg_data_i;
      end
      if (in_valid_i && !in_stall_i)
        patch_q.push_back(patch_predict(cmd_i, original_word_i, code_offset_i,
                                        field_mask_i, scale_i, value_i));
      if (out_valid_i && !out_stall_i) begin
        if (patch_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result word %h", patched_word_i);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = patch_q.pop_front();
          if (exp_r.word !== patched_word_i || exp_r.ptr !== pointer_value_i ||
              exp_r.err !== error_i) begin
            if (mismatches < 10)
              $display("mismatch: exp word %h ptr %h err %b, got word %h ptr %h err %b",
                       exp_r.word, exp_r.ptr, exp_r.err,
                       patched_word_i, pointer_value_i, error_i);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/instruction_relocation_patcher_test.sv =====
// ----------------------------------------------------------------------------
// instruction_relocation_patcher_test
// drives directed and random relocation requests through several register
// settings with random idling on both channels; ipr_checker does the scoring
// ----------------------------------------------------------------------------
module instruction_relocation_patcher_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic               cfg_idx;
  logic [47:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         cmd;
  logic [31:0]        word;
  logic [30:0]        offs;
  logic [31:0]        mask;
  logic signed [31:0] scale;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_stall;
  logic [31:0]        patched_word;
  logic [47:0]        pointer_value;
  logic               error;
  int unsigned        pending;
  int unsigned        fail_count;
  int unsigned        sent;
  int unsigned        rx_cycle;
  int unsigned        cfg_writes;

  instruction_relocation_patcher #(.ADDRESS_BITS(48)) u_dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .original_word_i(word), .code_offset_i(offs),
    .field_mask_i(mask), .scale_i(scale), .value_i(value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .patched_word_o(patched_word), .pointer_value_o(pointer_value), .error_o(error)
  );

  ipr_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .cmd_i(cmd), .original_word_i(word), .code_offset_i(offs),
    .field_mask_i(mask), .scale_i(scale), .value_i(value),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .patched_word_i(patched_word), .pointer_value_i(pointer_value), .error_i(error),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("instruction_relocation_patcher regression: fail");
    $finish;
  end

  // receiver: random stalls, a quiet stretch and one long hold-off
  initial begin
    out_stall = 1'b0;
    rx_cycle  = 0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_cycle >= 1500 && rx_cycle < 1900) out_stall <= 1'b1;
      else if (rx_cycle >= 800 && rx_cycle < 1200) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99) < 29);
    end
  end

  // one register write while idle
  task automatic reg_write(logic idx, logic [47:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cfg_writes++;
    @(posedge clk_i);
  endtask

  // hold a request until accepted, then maybe idle
  task automatic send_request(logic [2:0] c, logic [31:0] w, logic [30:0] o,
                              logic [31:0] m, logic [31:0] s, logic [31:0] v);
    in_valid <= 1'b1;
    cmd <= c; word <= w; offs <= o; mask <= m; scale <= s; value <= v;
    forever begin
      @(negedge clk_i);
      if (!in_stall) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    sent++;
    if (!(sent >= 600 && sent < 900) && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4, 5: return 32'(signed'($urandom_range(16)) - 8);
      6: return 32'd1 << $urandom_range(12);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(signed'($urandom_range(4000)) - 2000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_mask();
    int unsigned lo;
    int unsigned n;
    lo = $urandom_range(31);
    n  = $urandom_range(1, 32);
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return (n >= 32 ? 32'hFFFF_FFFF : ((32'd1 << n) - 1)) << lo;
    endcase
  endfunction

  // stimulus
  initial begin
    logic [2:0] c;
    cfg_we = 1'b0; cfg_idx = ipr_pkg::REG_DIST; cfg_data = '0;
    in_valid = 1'b0; cmd = '0; word = '0; offs = '0; mask = '0;
    scale = '0; value = '0;
    sent = 0; cfg_writes = 0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every kind, field extremes, zero scale, overflow, unknown kinds
    reg_write(ipr_pkg::REG_DIST, 48'h0000_0000_1000);
    reg_write(ipr_pkg::REG_BASE, 48'hFFFF_FFFF_F000);
    send_request(ipr_pkg::CMD_MASKED, 32'h0000_0000, 31'd0, 32'h0000_0FF0, 32'd4,
                 32'd100);
    send_request(ipr_pkg::CMD_MASKED, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'h8000_0000);
    send_request(ipr_pkg::CMD_MASKED, 32'h1234_5678, 31'd0, 32'h0000_0000, 32'd3,
                 32'hFFFF_FFF9);
    send_request(ipr_pkg::CMD_MASKED_DIST, 32'hA5A5_A5A5, 31'd4, 32'h00FF_FC00, 32'd4,
                 32'd64);
    send_request(ipr_pkg::CMD_MASKED_DIST, 32'h0, 31'd0, 32'hFFFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF);
    send_request(ipr_pkg::CMD_PAGE, 32'h9000_0000, 31'd8192, 32'h0, 32'd4096,
                 32'hFFFF_F001);
    send_request(ipr_pkg::CMD_PAGE, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h0, 32'hFFFF_F000,
                 32'h8000_0000);
    send_request(ipr_pkg::CMD_PAGE, 32'h0, 31'd0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(ipr_pkg::CMD_IMM16, 32'hE300_0000, 31'd0, 32'h0000_FFFF, 32'd1,
                 32'h0000_1FFF);
    send_request(ipr_pkg::CMD_IMM16, 32'hE340_0000, 31'd0, 32'hFFFF_0000, 32'h0001_0000,
                 32'hFFFF_FFFF);
    send_request(ipr_pkg::CMD_IMM16, 32'hFFFF_FFFF, 31'd0, 32'hFFFF_FFFF, 32'h8000_0000,
                 32'h8000_0000);
    send_request(ipr_pkg::CMD_POINTER, 32'h0, 31'd0, 32'h0, 32'd0, 32'h7FFF_FFFF);
    send_request(ipr_pkg::CMD_POINTER, 32'h0, 31'd0, 32'h0, 32'd5, 32'h8000_0000);
    for (int k = 0; k < 4; k++)
      send_request(3'(k), 32'hDEAD_BEEF, 31'd12, 32'hFFFF_FFFF, 32'd0, 32'd77);
    for (int k = 5; k < 8; k++)
      send_request(3'(k), 32'hCAFE_F00D, 31'd12, 32'hFFFF_FFFF, 32'd3, 32'd77);
    wait_drained();

    // random phases across register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          reg_write(ipr_pkg::REG_DIST, 48'd0);
          reg_write(ipr_pkg::REG_BASE, 48'd0);
        end
        1: begin
          reg_write(ipr_pkg::REG_DIST, 48'h0000_7FFF_FFFF);
          reg_write(ipr_pkg::REG_BASE, 48'hFFFF_FFFF_FFFF);
        end
        2: begin
          reg_write(ipr_pkg::REG_DIST, 48'h0000_8000_0000);
          reg_write(ipr_pkg::REG_BASE, 48'h0000_8000_0000);
        end
        default: begin
          reg_write(ipr_pkg::REG_DIST, 48'({$urandom, $urandom}));
          reg_write(ipr_pkg::REG_BASE, 48'({$urandom, $urandom}));
        end
      endcase
      for (int n = 0; n < 300; n++) begin
        c = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
        send_request(c, $urandom, 31'($urandom), pick_mask(), pick_scale(), pick_value());
      end
      wait_drained();
    end

    repeat (50) @(posedge clk_i);
    $display("sent %0d relocation requests over %0d register writes", sent, cfg_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("instruction_relocation_patcher regression: pass");
    end else begin
      $display("instruction_relocation_patcher regression: fail");
    end
    $finish;
  end

endmodule
